FILE: hdl/polar_pursuit_controller_top_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the polar pursuit controller
// Clocked, reset-qualified assertion wrappers; compiled out with NO_ASSERTIONS.
// -----------------------------------------------------------------------------
`ifndef POLAR_PURSUIT_CONTROLLER_TOP_MACROS_SVH
`define POLAR_PURSUIT_CONTROLLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define PPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define PPC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PPC_ASSERT(lbl, prop, msg)
`define PPC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: hdl/ppc_pkg.sv
// -----------------------------------------------------------------------------
// ppc_pkg
// Shared widths, constants, angle table and stage type of the pursuit controller.
// -----------------------------------------------------------------------------
package ppc_pkg;

  localparam int FIELD_W         = 16;
  localparam int GAIN_W          = 16;
  localparam int DATA_WIDTH      = 16;
  localparam int CORDIC_STAGES   = 16;
  localparam int GUARD_BITS      = 8;
  localparam int ANGLE_TABLE_LEN = 24;
  localparam int NUM_CELLS       = (CORDIC_STAGES < ANGLE_TABLE_LEN) ?
                                   CORDIC_STAGES : ANGLE_TABLE_LEN;
  localparam int SHIFT_W         = $clog2(ANGLE_TABLE_LEN);

  // datapath: offset plus guard bits plus headroom for rotation and CORDIC gain
  localparam int XW      = DATA_WIDTH + GUARD_BITS + 3;
  // angle accumulator, Q.30 radians with room for the pre-rotation
  localparam int ZW      = 34;
  localparam int ANGLE_W = 30;
  localparam int ANGLE_FRAC = 30;
  localparam int HEAD_SHIFT = ANGLE_FRAC - 12;
  localparam int HW      = ZW - HEAD_SHIFT;

  localparam int INV_W   = 20;
  localparam logic [INV_W-1:0] INV_GAIN_Q20 = INV_W'(636751);
  localparam int DIST_SHIFT = 28;
  localparam int PW      = (XW - 1) + INV_W;
  localparam int DISTW   = PW + 1 - DIST_SHIFT;
  localparam int SPW     = DISTW + GAIN_W;
  localparam int TPW     = HW + GAIN_W + 1;
  localparam int OUT_SHIFT = 12;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = ZW'(1686629713);

  localparam logic [ANGLE_W-1:0] ANGLE_TAB [ANGLE_TABLE_LEN] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  localparam logic [GAIN_W-1:0] SPEED_GAIN_RST = GAIN_W'(2048);
  localparam logic [GAIN_W-1:0] YAW_GAIN_RST   = GAIN_W'(4096);

  typedef enum logic {
    REG_SPEED_GAIN = 1'b0,
    REG_YAW_GAIN   = 1'b1
  } reg_addr_e;

  // one beat moving down the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } stage_t;

endpackage

FILE: hdl/ppc_front.sv
// -----------------------------------------------------------------------------
// ppc_front
// Scale the offset and pre-rotate it into the right half plane.
// -----------------------------------------------------------------------------
module ppc_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           take_i,
  input  logic [ppc_pkg::FIELD_W-1:0]    offset_x_i,
  input  logic [ppc_pkg::FIELD_W-1:0]    offset_y_i,
  output ppc_pkg::stage_t                q_o
);
  import ppc_pkg::*;

  localparam int EXT_W = XW - DATA_WIDTH - GUARD_BITS;

  logic signed [XW-1:0] xs, ys;
  stage_t               stage_d, stage_q;

  assign xs = {{EXT_W{offset_x_i[DATA_WIDTH-1]}}, offset_x_i[DATA_WIDTH-1:0],
               {GUARD_BITS{1'b0}}};
  assign ys = {{EXT_W{offset_y_i[DATA_WIDTH-1]}}, offset_y_i[DATA_WIDTH-1:0],
               {GUARD_BITS{1'b0}}};

  always_comb begin
    stage_d.valid = take_i;
    stage_d.zero  = (xs == '0) && (ys == '0);
    if (xs[XW-1]) begin
      if (!ys[XW-1]) begin
        stage_d.x = ys;
        stage_d.y = -xs;
        stage_d.z = HALF_PI_Q30;
      end else begin
        stage_d.x = -ys;
        stage_d.y = xs;
        stage_d.z = -HALF_PI_Q30;
      end
    end else begin
      stage_d.x = xs;
      stage_d.y = ys;
      stage_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign q_o = stage_q;

endmodule

FILE: hdl/ppc_cordic_cell.sv
// -----------------------------------------------------------------------------
// ppc_cordic_cell
// One vectoring micro-rotation: drive y toward zero and accumulate the angle.
// -----------------------------------------------------------------------------
module ppc_cordic_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [ppc_pkg::SHIFT_W-1:0]    shift_i,
  input  logic signed [ppc_pkg::ZW-1:0]  angle_i,
  input  ppc_pkg::stage_t                d_i,
  output ppc_pkg::stage_t                q_o
);
  import ppc_pkg::*;

  logic signed [XW-1:0] x_sh, y_sh;
  stage_t               stage_d, stage_q;

  assign x_sh = d_i.x >>> shift_i;
  assign y_sh = d_i.y >>> shift_i;

  always_comb begin
    stage_d.valid = d_i.valid;
    stage_d.zero  = d_i.zero;
    if (!d_i.y[XW-1]) begin
      stage_d.x = d_i.x + y_sh;
      stage_d.y = d_i.y - x_sh;
      stage_d.z = d_i.z + angle_i;
    end else begin
      stage_d.x = d_i.x - y_sh;
      stage_d.y = d_i.y + x_sh;
      stage_d.z = d_i.z - angle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign q_o = stage_q;

endmodule

FILE: hdl/ppc_back.sv
// -----------------------------------------------------------------------------
// ppc_back
// Gain-correct the magnitude, round the heading, apply gains and saturate.
// -----------------------------------------------------------------------------
module ppc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  ppc_pkg::stage_t                d_i,
  input  logic [ppc_pkg::GAIN_W-1:0]     speed_gain_i,
  input  logic [ppc_pkg::GAIN_W-1:0]     yaw_gain_i,
  output logic                           valid_o,
  output logic [ppc_pkg::FIELD_W-1:0]    linear_speed_o,
  output logic signed [ppc_pkg::FIELD_W-1:0] turn_rate_o
);
  import ppc_pkg::*;

  localparam int SVW = SPW + 1 - OUT_SHIFT;
  localparam int TVW = TPW + 1 - OUT_SHIFT;

  // step 1: magnitude correction product and rounded heading
  logic                 v1_q;
  logic [PW-1:0]        prod_d, prod_q;
  logic signed [ZW-1:0] zr;
  logic signed [HW-1:0] head_d, head_q;

  // step 2: gain products
  logic                  v2_q;
  logic [PW:0]           dsum;
  logic [DISTW-1:0]      mag;
  logic [SPW-1:0]        sp_d, sp_q;
  logic signed [TPW-1:0] tp_d, tp_q;

  // step 3: round and saturate
  logic                      v3_q;
  logic [SPW:0]              ssum;
  logic [SVW-1:0]            sv;
  logic signed [TPW:0]       tsum;
  logic signed [TVW-1:0]     tv;
  logic [FIELD_W-1:0]        speed_d, speed_q;
  logic signed [FIELD_W-1:0] turn_d, turn_q;

  assign zr     = d_i.z + ZW'(1 << (HEAD_SHIFT - 1));
  assign prod_d = d_i.zero ? '0 : PW'(d_i.x[XW-2:0]) * PW'(INV_GAIN_Q20);
  assign head_d = d_i.zero ? '0 : zr[ZW-1:HEAD_SHIFT];

  assign dsum = {1'b0, prod_q} + (PW+1)'(1 << (DIST_SHIFT - 1));
  assign mag  = dsum[PW:DIST_SHIFT];
  assign sp_d = SPW'(mag) * SPW'(speed_gain_i);
  assign tp_d = TPW'(head_q) * $signed({1'b0, yaw_gain_i});

  assign ssum = {1'b0, sp_q} + (SPW+1)'(1 << (OUT_SHIFT - 1));
  assign sv   = ssum[SPW:OUT_SHIFT];
  assign tsum = {tp_q[TPW-1], tp_q} + (TPW+1)'(1 << (OUT_SHIFT - 1));
  assign tv   = tsum[TPW:OUT_SHIFT];

  always_comb begin
    // clamp to the top of the unsigned range
    if (|sv[SVW-1:FIELD_W]) begin
      speed_d = '1;
    end else begin
      speed_d = sv[FIELD_W-1:0];
    end
    // clamp to the signed range
    if (tv[TVW-1] && !(&tv[TVW-2:FIELD_W-1])) begin
      turn_d = {1'b1, {(FIELD_W-1){1'b0}}};
    end else if (!tv[TVW-1] && (|tv[TVW-2:FIELD_W-1])) begin
      turn_d = {1'b0, {(FIELD_W-1){1'b1}}};
    end else begin
      turn_d = tv[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= d_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      head_q  <= head_d;
      sp_q    <= sp_d;
      tp_q    <= tp_d;
      speed_q <= speed_d;
      turn_q  <= turn_d;
    end
  end

  assign valid_o        = v3_q;
  assign linear_speed_o = speed_q;
  assign turn_rate_o    = turn_q;

endmodule

FILE: hdl/polar_pursuit_controller_top.sv
// Pipeline from input beat to output beat:
//   one front stage, one cell per CORDIC iteration, three back stages, output register.
// Throughput: one offset per cycle while the skid slot is empty; the CORDIC cells move only then.
// Offsets with transform_valid low are taken and dropped without a result.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and skid and loads
//   the speed gain = 0.5 and the yaw gain = 1.0 (Q4.12).
// -----------------------------------------------------------------------------
// polar_pursuit_controller_top
// Proportional pursuit: CORDIC vectoring gives range and bearing, gains give the
// speed and yaw-rate commands. Gains sit behind a small APB register port.
// -----------------------------------------------------------------------------
`include "polar_pursuit_controller_top_macros.svh"

module polar_pursuit_controller_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // offset input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               transform_valid_i,
  input  logic signed [ppc_pkg::FIELD_W-1:0] offset_x_i,
  input  logic signed [ppc_pkg::FIELD_W-1:0] offset_y_i,
  // command output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ppc_pkg::FIELD_W-1:0]        linear_speed_o,
  output logic signed [ppc_pkg::FIELD_W-1:0] turn_rate_o,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ppc_pkg::*;

  // ---------------------------------------------------------------------------
  // Gain registers. Decode on the word address bit; byte lanes are ignored.
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0] lin_gain_d, lin_gain_q;
  logic [GAIN_W-1:0] ang_gain_d, ang_gain_q;
  logic              reg_wr;
  reg_addr_e         reg_addr;

  assign pready   = 1'b1;
  assign reg_wr   = psel && penable && pwrite && pready;
  assign reg_addr = reg_addr_e'(paddr[2]);

  always_comb begin
    lin_gain_d = lin_gain_q;
    ang_gain_d = ang_gain_q;
    prdata     = '0;
    case (reg_addr)
      REG_SPEED_GAIN: begin
        prdata = {{(32-GAIN_W){1'b0}}, lin_gain_q};
        if (reg_wr) begin
          lin_gain_d = pwdata[GAIN_W-1:0];
        end
      end
      REG_YAW_GAIN: begin
        prdata = {{(32-GAIN_W){1'b0}}, ang_gain_q};
        if (reg_wr) begin
          ang_gain_d = pwdata[GAIN_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_gain_q <= SPEED_GAIN_RST;
      ang_gain_q <= YAW_GAIN_RST;
    end else begin
      lin_gain_q <= lin_gain_d;
      ang_gain_q <= ang_gain_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline enable. The whole chain advances unless the skid slot is full,
  // so a waiting result in the output register never blocks the input side.
  // ---------------------------------------------------------------------------
  logic pipe_en;
  logic take;

  logic                      out_valid_d, out_valid_q;
  logic [FIELD_W-1:0]        out_speed_d, out_speed_q;
  logic signed [FIELD_W-1:0] out_turn_d, out_turn_q;
  logic                      skid_valid_d, skid_valid_q;
  logic [FIELD_W-1:0]        skid_speed_d, skid_speed_q;
  logic signed [FIELD_W-1:0] skid_turn_d, skid_turn_q;
  logic                      out_load;
  logic                      res_beat;

  assign pipe_en    = !skid_valid_q;
  assign in_ready_o = pipe_en;
  // a failed lookup enters as a bubble
  assign take       = in_valid_i && in_ready_o && transform_valid_i;

  stage_t chain [NUM_CELLS+1];

  ppc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .take_i     (take),
    .offset_x_i (offset_x_i),
    .offset_y_i (offset_y_i),
    .q_o        (chain[0])
  );

  // One cell per micro-rotation; cell i shifts by i and adds or subtracts atan(2^-i).
  for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
    ppc_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .shift_i (SHIFT_W'(gi)),
      .angle_i ($signed({{(ZW-ANGLE_W){1'b0}}, ANGLE_TAB[gi]})),
      .d_i     (chain[gi]),
      .q_o     (chain[gi+1])
    );
  end

  logic                      res_valid;
  logic [FIELD_W-1:0]        res_speed;
  logic signed [FIELD_W-1:0] res_turn;

  ppc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (pipe_en),
    .d_i            (chain[NUM_CELLS]),
    .speed_gain_i   (lin_gain_q),
    .yaw_gain_i     (ang_gain_q),
    .valid_o        (res_valid),
    .linear_speed_o (res_speed),
    .turn_rate_o    (res_turn)
  );

  // ---------------------------------------------------------------------------
  // Output register plus one skid slot. A result leaving the pipeline goes to
  // the output register when it is free, otherwise parks in the skid slot.
  // ---------------------------------------------------------------------------
  assign out_load = !out_valid_q || out_ready_i;
  assign res_beat = pipe_en && res_valid;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_speed_d  = out_speed_q;
    out_turn_d   = out_turn_q;
    skid_valid_d = skid_valid_q;
    skid_speed_d = skid_speed_q;
    skid_turn_d  = skid_turn_q;
    if (out_load) begin
      if (skid_valid_q) begin
        // drain the parked beat first
        out_valid_d  = 1'b1;
        out_speed_d  = skid_speed_q;
        out_turn_d   = skid_turn_q;
        skid_valid_d = 1'b0;
      end else if (res_beat) begin
        out_valid_d = 1'b1;
        out_speed_d = res_speed;
        out_turn_d  = res_turn;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (res_beat) begin
      // output stalled: park the new beat
      skid_valid_d = 1'b1;
      skid_speed_d = res_speed;
      skid_turn_d  = res_turn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_speed_q  <= out_speed_d;
    out_turn_q   <= out_turn_d;
    skid_speed_q <= skid_speed_d;
    skid_turn_q  <= skid_turn_d;
  end

  assign out_valid_o    = out_valid_q;
  assign linear_speed_o = out_speed_q;
  assign turn_rate_o    = out_turn_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PPC_ASSERT_NEVER(a_skid_without_out, skid_valid_q && !out_valid_q,
                    "skid holds a beat while output is empty")
  `PPC_ASSERT(a_skid_holds, skid_valid_q && !out_ready_i |=>
              skid_valid_q && $stable(skid_speed_q) && $stable(skid_turn_q),
              "skid beat lost or changed under stall")
  `PPC_ASSERT(a_skid_fill_cause,
              $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i && res_valid),
              "skid filled without an output stall")

endmodule
